// ===== sv/itoa_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Integer to ASCII formatter package
// Shared types, character codes, limits and the digit character function.
// ----------------------------------------------------------------------------
package itoa_pkg;

   // Payload types
   typedef logic [63:0] value_type;
   typedef logic [7:0]  char_type;
   typedef logic [5:0]  radix_type;
   typedef logic [6:0]  count_type;

   // Output length limit default and digit store geometry
   localparam int MAX_CHARS_DEFAULT = 64;
   localparam int DIGIT_DEPTH       = 64;
   localparam int DIGIT_AW          = $clog2(DIGIT_DEPTH);
   localparam int LEN_W             = 8;

   // Divider geometry: magnitude bits consumed per cycle
   localparam int VALUE_W      = 64;
   localparam int DIV_STEPS    = 8;
   localparam int DIV_CYCLES   = VALUE_W / DIV_STEPS;
   localparam int DIV_CNT_W    = $clog2(DIV_CYCLES);

   // Valid radix range
   localparam radix_type RADIX_MIN = 6'd2;
   localparam radix_type RADIX_MAX = 6'd36;
   localparam radix_type RADIX_OCT = 6'd8;
   localparam radix_type RADIX_HEX = 6'd16;

   // Character codes
   localparam char_type CH_NUL   = 8'h00;
   localparam char_type CH_SPACE = 8'h20;
   localparam char_type CH_PLUS  = 8'h2B;
   localparam char_type CH_MINUS = 8'h2D;
   localparam char_type CH_ZERO  = 8'h30;
   localparam char_type CH_X     = 8'h78;
   localparam char_type CH_UP_A  = 8'h41;
   localparam char_type CH_LO_A  = 8'h61;

   // Map a digit value below 36 to its character in the chosen case.
   function automatic char_type digit_char(input radix_type dval, input logic upper);
      char_type base;
      begin
         if (dval < 6'd10) begin
            digit_char = CH_ZERO + {2'b00, dval};
         end else begin
            base = upper ? CH_UP_A : CH_LO_A;
            digit_char = base + {2'b00, dval} - 8'd10;
         end
      end
   endfunction

endpackage
`default_nettype wire

// ===== sv/itoa_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module itoa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule
`default_nettype wire

// ===== sv/itoa_divider.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Iterative radix divider
// Long division of a 64-bit magnitude by a small radix, several quotient
// bits per cycle, giving the quotient and the remainder as the next digit.
// ----------------------------------------------------------------------------
module itoa_divider (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  wire itoa_pkg::value_type dividend,
   input  wire itoa_pkg::radix_type radix,
   output logic                    done,
   output itoa_pkg::value_type     quotient,
   output itoa_pkg::radix_type     remainder
);
   import itoa_pkg::*;

   logic                 run_ff, run_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] step_ff, step_in;
   value_type            quo_ff, quo_in;
   radix_type            rem_ff, rem_in;
   value_type            q_work;
   radix_type            r_work;
   logic [6:0]           trial;

   // A handful of restoring division steps on the narrow remainder.
   always_comb begin
      q_work = quo_ff;
      r_work = rem_ff;
      trial  = '0;
      for (int i = 0; i < DIV_STEPS; i++) begin
         trial  = {r_work, q_work[VALUE_W-1]};
         q_work = {q_work[VALUE_W-2:0], 1'b0};
         if (trial >= {1'b0, radix}) begin
            r_work    = 6'(trial - {1'b0, radix});
            q_work[0] = 1'b1;
         end else begin
            r_work = trial[5:0];
         end
      end
   end

   // Sequencing of the division passes.
   always_comb begin
      run_in  = run_ff;
      done_in = 1'b0;
      step_in = step_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      if (start) begin
         run_in  = 1'b1;
         step_in = '0;
         quo_in  = dividend;
         rem_in  = '0;
      end else if (run_ff) begin
         quo_in  = q_work;
         rem_in  = r_work;
         step_in = step_ff + DIV_CNT_W'(1);
         if (step_ff == DIV_CNT_W'(DIV_CYCLES - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule
`default_nettype wire

// ===== sv/integer_to_ascii_formatter.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Integer to ASCII formatter
// Converts one integer per request to printf-style characters in radix
// 2 to 36, one character per response, with sign, prefix and padding.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake              Payload
//  req_      in         req_valid / req_ready  value, width mode, radix, flags
//  rsp_      out        rsp_valid / rsp_ready  character, last, errors
//
//  The shared divider yields one digit per division (a load and its passes),
//  and each character spends one state on the digit store read and one on display.
//  A bad radix puts its single error response out in the cycle after acceptance.
//  req_ready is high only while no request is in progress; a stalled response
//  holds all its fields. Synchronous reset returns the sequencer to idle.
// ----------------------------------------------------------------------------
module integer_to_ascii_formatter #(
   parameter int MAX_CHARS = itoa_pkg::MAX_CHARS_DEFAULT
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_ready,
   input  wire itoa_pkg::value_type req_value,
   input  wire logic                req_wide_value,
   input  wire itoa_pkg::radix_type req_radix,
   input  wire itoa_pkg::count_type req_min_width,
   input  wire itoa_pkg::count_type req_min_digits,
   input  wire logic                req_left_align,
   input  wire logic                req_plus_sign,
   input  wire logic                req_space_sign,
   input  wire logic                req_alt_prefix,
   input  wire logic                req_zero_pad,
   input  wire logic                req_signed_mode,
   input  wire logic                req_upper_case,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output itoa_pkg::char_type       rsp_out_char,
   output logic                     rsp_last_char,
   output logic                     rsp_bad_radix,
   output logic                     rsp_cut_off
);
   import itoa_pkg::*;

   localparam int POS_W = $clog2(MAX_CHARS);

   // Sequencer codes
   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_ERR    = 3'd1;
   localparam logic [2:0] S_PREP   = 3'd2;
   localparam logic [2:0] S_DIV    = 3'd3;
   localparam logic [2:0] S_SIZE   = 3'd4;
   localparam logic [2:0] S_LAYOUT = 3'd5;
   localparam logic [2:0] S_FETCH  = 3'd6;
   localparam logic [2:0] S_SHOW   = 3'd7;

   logic [2:0]       state_ff, state_in;

   // Captured request
   value_type        value_ff;
   logic             wide_ff, left_ff, plus_ff, space_ff, alt_ff, zpad_ff, sgn_ff, upper_ff;
   radix_type        radix_ff;
   count_type        width_ff, prec_ff;

   // Per-request working state
   char_type         sign_ch_ff, sign_ch_in;
   logic             has_sign_ff, has_sign_in;
   logic [1:0]       prefix_ff, prefix_in;
   count_type        digit_count_ff, digit_count_in;
   count_type        prec_eff_ff, prec_eff_in;
   count_type        pad_ff, pad_in;
   logic [LEN_W-1:0] e_lead_ff, e_sign_ff, e_pref_ff, e_prec_ff, e_dig_ff;
   logic [LEN_W-1:0] e_lead_in, e_sign_in, e_pref_in, e_prec_in, e_dig_in;
   logic [POS_W-1:0] pos_ff, pos_in, last_pos_ff, last_pos_in;
   logic             cut_ff, cut_in;

   // Combinational helpers
   value_type        ext_value, magnitude, div_dividend, div_quotient;
   radix_type        div_remainder;
   logic             neg, div_start, div_done, finish;
   logic             ram_wr_en, ram_rd_en;
   char_type         ram_rd_data, show_char;
   logic signed [8:0] size_s;
   count_type        prec_eff;
   logic [LEN_W-1:0] pad_w, lead_w, zero_w, trail_w, total_w, total_m1, pos_x, dig_idx;
   logic             accept, bad_radix, zpad_eff, is_last;

   assign accept    = req_valid && req_ready;
   assign bad_radix = (req_radix < RADIX_MIN) || (req_radix > RADIX_MAX);
   assign zpad_eff  = zpad_ff && !left_ff;

   // Magnitude and sign from the captured value.
   always_comb begin
      if (wide_ff) begin
         ext_value = value_ff;
      end else begin
         ext_value = {{32{sgn_ff & value_ff[31]}}, value_ff[31:0]};
      end
      neg       = sgn_ff && ext_value[VALUE_W-1];
      magnitude = neg ? (~ext_value + 64'd1) : ext_value;
   end

   // Divider hookup: first pass from the magnitude, later ones from the quotient.
   assign finish       = (div_quotient == '0) || (digit_count_ff == 7'(DIGIT_DEPTH - 1));
   assign div_start    = (state_ff == S_PREP) || ((state_ff == S_DIV) && div_done && !finish);
   assign div_dividend = (state_ff == S_PREP) ? magnitude : div_quotient;
   assign ram_wr_en    = (state_ff == S_DIV) && div_done;

   itoa_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .radix     (radix_ff),
      .done      (div_done),
      .quotient  (div_quotient),
      .remainder (div_remainder)
   );

   // Field size arithmetic.
   always_comb begin
      prec_eff = (prec_ff > digit_count_ff) ? prec_ff : digit_count_ff;
      size_s   = $signed({2'b00, width_ff}) - $signed({8'b0, has_sign_ff})
               - $signed({7'b0, prefix_ff}) - $signed({2'b00, prec_eff});
      pad_w    = {1'b0, pad_ff};
      lead_w   = (!zpad_eff && !left_ff) ? pad_w : '0;
      zero_w   = zpad_eff ? pad_w : '0;
      trail_w  = left_ff ? pad_w : '0;
      total_w  = pad_w + {7'b0, has_sign_ff} + {6'b0, prefix_ff} + {1'b0, prec_eff_ff};
      total_m1 = total_w - 8'd1;
   end

   // Character selection by position within the segments.
   assign pos_x   = {{(LEN_W - POS_W){1'b0}}, pos_ff};
   assign dig_idx = e_dig_ff - 8'd1 - pos_x;
   assign ram_rd_en = (state_ff == S_FETCH);

   itoa_ram #(
      .WIDTH (8),
      .DEPTH (DIGIT_DEPTH)
   ) u_digit_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (digit_count_ff[DIGIT_AW-1:0]),
      .wr_data (digit_char(div_remainder, upper_ff)),
      .rd_en   (ram_rd_en),
      .rd_addr (dig_idx[DIGIT_AW-1:0]),
      .rd_data (ram_rd_data)
   );

   always_comb begin
      if (pos_x < e_lead_ff) begin
         show_char = CH_SPACE;
      end else if (pos_x < e_sign_ff) begin
         show_char = sign_ch_ff;
      end else if (pos_x < e_pref_ff) begin
         show_char = (pos_x == e_sign_ff) ? CH_ZERO : CH_X;
      end else if (pos_x < e_prec_ff) begin
         show_char = CH_ZERO;
      end else if (pos_x < e_dig_ff) begin
         show_char = ram_rd_data;
      end else begin
         show_char = CH_SPACE;
      end
   end

   assign is_last = (pos_ff == last_pos_ff);

   // Sequencer next state.
   always_comb begin
      state_in       = state_ff;
      sign_ch_in     = sign_ch_ff;
      has_sign_in    = has_sign_ff;
      prefix_in      = prefix_ff;
      digit_count_in = digit_count_ff;
      prec_eff_in    = prec_eff_ff;
      pad_in         = pad_ff;
      e_lead_in      = e_lead_ff;
      e_sign_in      = e_sign_ff;
      e_pref_in      = e_pref_ff;
      e_prec_in      = e_prec_ff;
      e_dig_in       = e_dig_ff;
      pos_in         = pos_ff;
      last_pos_in    = last_pos_ff;
      cut_in         = cut_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = bad_radix ? S_ERR : S_PREP;
            end
         end
         S_ERR: begin
            if (rsp_ready) begin
               state_in = S_IDLE;
            end
         end
         S_PREP: begin
            has_sign_in    = sgn_ff && (neg || plus_ff || space_ff);
            sign_ch_in     = neg ? CH_MINUS : (plus_ff ? CH_PLUS : CH_SPACE);
            prefix_in      = !alt_ff ? 2'd0 : (radix_ff == RADIX_HEX) ? 2'd2 :
                             (radix_ff == RADIX_OCT) ? 2'd1 : 2'd0;
            digit_count_in = '0;
            state_in       = S_DIV;
         end
         S_DIV: begin
            if (div_done) begin
               digit_count_in = digit_count_ff + 7'd1;
               if (finish) begin
                  state_in = S_SIZE;
               end
            end
         end
         S_SIZE: begin
            prec_eff_in = prec_eff;
            pad_in      = (size_s > 9'sd0) ? size_s[6:0] : '0;
            state_in    = S_LAYOUT;
         end
         S_LAYOUT: begin
            e_lead_in   = lead_w;
            e_sign_in   = lead_w + {7'b0, has_sign_ff};
            e_pref_in   = e_sign_in + {6'b0, prefix_ff};
            e_prec_in   = e_pref_in + zero_w + {1'b0, prec_eff_ff - digit_count_ff};
            e_dig_in    = e_prec_in + {1'b0, digit_count_ff};
            cut_in      = total_w > LEN_W'(MAX_CHARS);
            last_pos_in = cut_in ? POS_W'(MAX_CHARS - 1) : total_m1[POS_W-1:0];
            pos_in      = '0;
            state_in    = S_FETCH;
         end
         S_FETCH: begin
            state_in = S_SHOW;
         end
         S_SHOW: begin
            if (rsp_ready) begin
               if (is_last) begin
                  state_in = S_IDLE;
               end else begin
                  pos_in   = pos_ff + POS_W'(1);
                  state_in = S_FETCH;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Registers: sequencer state under reset, captured request loaded on acceptance, working state free-running.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
      if (accept) begin
         value_ff <= req_value;
         wide_ff  <= req_wide_value;
         radix_ff <= req_radix;
         width_ff <= req_min_width;
         prec_ff  <= req_min_digits;
         left_ff  <= req_left_align;
         plus_ff  <= req_plus_sign;
         space_ff <= req_space_sign;
         alt_ff   <= req_alt_prefix;
         zpad_ff  <= req_zero_pad;
         sgn_ff   <= req_signed_mode;
         upper_ff <= req_upper_case;
      end
      sign_ch_ff     <= sign_ch_in;
      has_sign_ff    <= has_sign_in;
      prefix_ff      <= prefix_in;
      digit_count_ff <= digit_count_in;
      prec_eff_ff    <= prec_eff_in;
      pad_ff         <= pad_in;
      e_lead_ff      <= e_lead_in;
      e_sign_ff      <= e_sign_in;
      e_pref_ff      <= e_pref_in;
      e_prec_ff      <= e_prec_in;
      e_dig_ff       <= e_dig_in;
      pos_ff         <= pos_in;
      last_pos_ff    <= last_pos_in;
      cut_ff         <= cut_in;
   end

   // Port outputs.
   assign req_ready     = (state_ff == S_IDLE);
   assign rsp_valid     = (state_ff == S_SHOW) || (state_ff == S_ERR);
   assign rsp_out_char  = (state_ff == S_ERR) ? CH_NUL : show_char;
   assign rsp_last_char = (state_ff == S_ERR) || is_last;
   assign rsp_bad_radix = (state_ff == S_ERR);
   assign rsp_cut_off   = (state_ff == S_SHOW) && is_last && cut_ff;

endmodule
`default_nettype wire

// ===== sv/itoa_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Integer to ASCII formatter checker
// Port-level properties of the formatter, attached by a bind statement.
// ----------------------------------------------------------------------------
module itoa_checker (
   input wire logic                clock,
   input wire logic                reset,
   input wire logic                req_valid,
   input wire logic                req_ready,
   input wire itoa_pkg::radix_type req_radix,
   input wire logic                rsp_valid,
   input wire logic                rsp_ready,
   input wire itoa_pkg::char_type  rsp_out_char,
   input wire logic                rsp_last_char,
   input wire logic                rsp_bad_radix,
   input wire logic                rsp_cut_off
);
   import itoa_pkg::*;

   // A new request is never taken while a response is on offer.
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("request accepted while a response is pending");

   // A request with an unusable radix is answered at once by the error response.
   a_bad_answer: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && ((req_radix < RADIX_MIN) || (req_radix > RADIX_MAX))
      |=> rsp_valid && rsp_bad_radix)
      else $error("bad radix not answered by an error response");

   // The error response is a lone, empty, final response.
   a_bad_form: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_bad_radix |-> rsp_last_char && (rsp_out_char == CH_NUL) && !rsp_cut_off)
      else $error("malformed error response");

   // Truncation is reported on the final character only.
   a_cut_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_cut_off |-> rsp_last_char)
      else $error("cut off flagged before the final character");

   // A stalled response holds its character.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_char) && $stable(rsp_last_char))
      else $error("stalled response changed");

endmodule

bind integer_to_ascii_formatter itoa_checker u_itoa_checker (.*);
`default_nettype wire
